### design/sdrl_pkg.sv
// Shared types and constants for the serial delay register loader.
package sdrl_pkg;

  localparam int SETUP_W        = 10;
  localparam int HALF_W         = 16;
  localparam int TIMER_W        = HALF_W + 1;
  localparam int CHAN_W         = 8;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_IDX_W      = 1;

  localparam int BITS_PER_CHANNEL_DEF = 8;
  localparam int READBACK_PASSES_DEF  = 2;

  localparam logic [SETUP_W-1:0] SETUP_TICKS_RST = SETUP_W'(20);
  localparam logic [HALF_W-1:0]  HALF_TICKS_RST  = HALF_W'(500);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETUP_TICKS = 1'b0,
    CFG_HALF_PERIOD = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SETUP  = 3'd1,
    PH_HIGH   = 3'd2,
    PH_LOW    = 3'd3,
    PH_GAP    = 3'd4,
    PH_RSETUP = 3'd5,
    PH_RHIGH  = 3'd6,
    PH_RLOW   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_VERIFIED = 2'd1,
    ST_RANGE    = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  typedef struct packed {
    logic              action;
    logic [CHAN_W-1:0] channel_a;
    logic [CHAN_W-1:0] channel_b;
    logic              q_level;
  } in_item_t;

  typedef struct packed {
    logic    pin_d;
    logic    pin_clk;
    logic    pin_le;
    logic    pin_oe;
    logic    busy_res;
    status_t status;
  } out_item_t;

  typedef struct packed {
    logic d;
    logic clk;
    logic le;
    logic oe;
  } pins_t;

  typedef struct packed {
    logic [SETUP_W-1:0] setup_ticks;
    logic [HALF_W-1:0]  half_period_ticks;
  } cfg_t;

endpackage

### design/sdrl_ifs.sv
// Valid/ready channel interfaces for the loader's input and result beats.
interface sdrl_in_if;
  logic               valid;
  logic               ready;
  sdrl_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sdrl_out_if;
  logic                valid;
  logic                ready;
  sdrl_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/sdrl_seq.sv
// Load/readback sequencer: phase, timer, bit and pass counters, shift data, pin state and status.
module sdrl_seq #(
  parameter int BITS_PER_CHANNEL = sdrl_pkg::BITS_PER_CHANNEL_DEF,
  parameter int READBACK_PASSES  = sdrl_pkg::READBACK_PASSES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  sdrl_pkg::in_item_t  item,
  input  sdrl_pkg::cfg_t      cfg,
  output sdrl_pkg::out_item_t result
);
  import sdrl_pkg::*;

  localparam int NBITS  = 2 * BITS_PER_CHANNEL;
  localparam int BI_W   = $clog2(NBITS + 1);
  localparam int PASS_W = (READBACK_PASSES > 1) ? $clog2(READBACK_PASSES) : 1;

  phase_t             phase_r, phase_nxt;
  logic [BI_W-1:0]    bit_idx_r, bit_idx_nxt;
  logic [PASS_W-1:0]  pass_r, pass_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic [NBITS-1:0]   shift_r, shift_nxt;
  logic               mismatch_r, mismatch_nxt;
  pins_t              pins_r, pins_nxt;
  status_t            status_r, status_nxt;

  logic [TIMER_W-1:0] timer_inc;
  logic [TIMER_W-1:0] limit;
  logic [HALF_W-1:0]  high_wait;
  logic [BI_W-1:0]    bit_inc;
  logic [NBITS-1:0]   shift_rot;
  logic [NBITS-1:0]   load_word;
  logic               wait_done;
  logic               last_bit;
  logic               end_bits;
  logic               more_passes;
  logic               range_bad;
  logic               start_ok;

  assign timer_inc   = timer_r + TIMER_W'(1);
  assign high_wait   = (cfg.half_period_ticks > HALF_W'(cfg.setup_ticks)) ?
                       cfg.half_period_ticks - HALF_W'(cfg.setup_ticks) : '0;
  assign bit_inc     = bit_idx_r + BI_W'(1);
  assign last_bit    = bit_idx_r >= BI_W'(NBITS - 1);
  assign end_bits    = bit_inc >= BI_W'(NBITS);
  assign more_passes = pass_r < PASS_W'(READBACK_PASSES - 1);
  assign shift_rot   = {shift_r[NBITS-2:0], shift_r[NBITS-1]};
  assign load_word   = {BITS_PER_CHANNEL'(item.channel_a), BITS_PER_CHANNEL'(item.channel_b)};

  assign range_bad = (item.channel_a == '0) || (item.channel_b == '0) ||
                     ((item.channel_a >> BITS_PER_CHANNEL) != '0) ||
                     ((item.channel_b >> BITS_PER_CHANNEL) != '0);
  assign start_ok  = item.action && !range_bad;

  // wait limit of the current phase
  always_comb begin
    unique case (phase_r)
      PH_SETUP, PH_RSETUP: limit = TIMER_W'(cfg.setup_ticks);
      PH_HIGH, PH_RHIGH:   limit = TIMER_W'(high_wait);
      PH_LOW, PH_RLOW:     limit = TIMER_W'(cfg.half_period_ticks);
      PH_GAP:              limit = {cfg.half_period_ticks, 1'b0};
      default:             limit = '0;
    endcase
  end

  assign wait_done = timer_inc >= limit;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      unique case (phase_r)
        PH_IDLE:   if (start_ok) phase_nxt = PH_SETUP;
        PH_SETUP:  if (wait_done) phase_nxt = PH_HIGH;
        PH_HIGH:   if (wait_done) phase_nxt = PH_LOW;
        PH_LOW:    if (wait_done) phase_nxt = end_bits ? PH_GAP : PH_SETUP;
        PH_GAP:    if (wait_done) phase_nxt = PH_RSETUP;
        PH_RSETUP: if (wait_done) phase_nxt = PH_RHIGH;
        PH_RHIGH:  if (wait_done) phase_nxt = PH_RLOW;
        PH_RLOW: begin
          if (wait_done) begin
            phase_nxt = (!end_bits || more_passes) ? PH_RSETUP : PH_IDLE;
          end
        end
        default:   phase_nxt = PH_IDLE;
      endcase
    end
  end

  // counters, data and pins
  always_comb begin
    bit_idx_nxt  = bit_idx_r;
    pass_nxt     = pass_r;
    timer_nxt    = timer_r;
    shift_nxt    = shift_r;
    mismatch_nxt = mismatch_r;
    pins_nxt     = pins_r;
    status_nxt   = status_r;
    if (step) begin
      if (phase_r == PH_IDLE) begin
        if (item.action) begin
          if (range_bad) begin
            status_nxt = ST_RANGE;
          end else begin
            shift_nxt    = load_word;
            mismatch_nxt = 1'b0;
            status_nxt   = ST_NONE;
            bit_idx_nxt  = '0;
            pass_nxt     = '0;
            timer_nxt    = '0;
            pins_nxt     = '{d: load_word[NBITS-1], clk: 1'b0, le: 1'b1, oe: 1'b1};
          end
        end
      end else begin
        timer_nxt = timer_inc;
        if (wait_done) begin
          timer_nxt = '0;
          unique case (phase_r)
            PH_SETUP: pins_nxt.clk = 1'b1;
            PH_HIGH: begin
              pins_nxt.clk = 1'b0;
              if (last_bit) pins_nxt.le = 1'b0;
            end
            PH_LOW: begin
              bit_idx_nxt = bit_inc;
              shift_nxt   = shift_rot;
              if (!end_bits) pins_nxt.d = shift_rot[NBITS-1];
            end
            PH_GAP: begin
              pass_nxt    = '0;
              bit_idx_nxt = '0;
              pins_nxt.clk = 1'b0;
              pins_nxt.oe  = 1'b0;
              pins_nxt.le  = 1'b1;
            end
            PH_RSETUP: begin
              if (item.q_level != shift_r[NBITS-1]) mismatch_nxt = 1'b1;
              pins_nxt.clk = 1'b1;
            end
            PH_RHIGH: begin
              pins_nxt.clk = 1'b0;
              if (last_bit) pins_nxt.le = 1'b0;
            end
            PH_RLOW: begin
              bit_idx_nxt = bit_inc;
              shift_nxt   = shift_rot;
              if (end_bits) begin
                if (more_passes) begin
                  pass_nxt     = pass_r + PASS_W'(1);
                  bit_idx_nxt  = '0;
                  pins_nxt.clk = 1'b0;
                  pins_nxt.oe  = 1'b0;
                  pins_nxt.le  = 1'b1;
                end else begin
                  status_nxt = mismatch_r ? ST_MISMATCH : ST_VERIFIED;
                end
              end
            end
            default: timer_nxt = '0;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_idx_r  <= '0;
      pass_r     <= '0;
      timer_r    <= '0;
      shift_r    <= '0;
      mismatch_r <= 1'b0;
      pins_r     <= '{d: 1'b0, clk: 1'b0, le: 1'b0, oe: 1'b1};
      status_r   <= ST_NONE;
    end else begin
      phase_r    <= phase_nxt;
      bit_idx_r  <= bit_idx_nxt;
      pass_r     <= pass_nxt;
      timer_r    <= timer_nxt;
      shift_r    <= shift_nxt;
      mismatch_r <= mismatch_nxt;
      pins_r     <= pins_nxt;
      status_r   <= status_nxt;
    end
  end

  // result of the beat being accepted: state after the update
  assign result = '{pin_d:    pins_nxt.d,
                    pin_clk:  pins_nxt.clk,
                    pin_le:   pins_nxt.le,
                    pin_oe:   pins_nxt.oe,
                    busy_res: (phase_nxt != PH_IDLE),
                    status:   status_nxt};

endmodule

### design/serial_delay_register_loader_top.sv
// Top level of the serial delay register loader: handshake, config, result register.
//
//  channel  dir  handshake        payload
//  in_ch    in   valid/ready      action, channel_a, channel_b, q_level
//  out_ch   out  valid/ready      pin_d, pin_clk, pin_le, pin_oe, busy_res, status
//  cfg_*    in   write enable     cfg_index selects setup_ticks / half_period_ticks
//
// One input beat per cycle while out_ch is not stalled; each beat gives exactly one result
// beat, registered and valid in the following cycle, from a single output register.
// The sequencer state updates in the cycle a beat is accepted; the result is
// the pin and status view after that update.
// in_ch.ready is high whenever the output register is empty or being drained,
// so a stall on out_ch holds off in_ch for as long as a result sits unread.
// Synchronous active-low reset: idle, pins D/CLK/LE low, OE high, status none,
// setup 20 and half period 500 ticks.
module serial_delay_register_loader_top #(
  parameter int BITS_PER_CHANNEL = sdrl_pkg::BITS_PER_CHANNEL_DEF,
  parameter int READBACK_PASSES  = sdrl_pkg::READBACK_PASSES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  sdrl_in_if.sink                             in_ch,
  sdrl_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [sdrl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sdrl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import sdrl_pkg::*;

  cfg_t      cfg_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  out_item_t seq_result;
  logic      in_ready;
  logic      step;

  // config registers; writes must arrive only while idle, which the block itself does not enforce
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setup_ticks       <= SETUP_TICKS_RST;
      cfg_r.half_period_ticks <= HALF_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SETUP_TICKS: cfg_r.setup_ticks       <= cfg_wdata[SETUP_W-1:0];
        CFG_HALF_PERIOD: cfg_r.half_period_ticks <= cfg_wdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // input beat taken when the result slot is free or emptying
  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign step        = in_ch.valid && in_ready;

  sdrl_seq #(
    .BITS_PER_CHANNEL (BITS_PER_CHANNEL),
    .READBACK_PASSES  (READBACK_PASSES)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_ch.data),
    .cfg    (cfg_r),
    .result (seq_result)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= seq_result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // every accepted beat leaves a result behind
  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("accepted beat produced no result");

  // a running sequence never reports a final status
  a_busy_status_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.busy_res) |-> (out_data_r.status == ST_NONE))
    else $error("status set while sequence running");

  // serial clock is only ever high inside a sequence
  a_clk_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.pin_clk) |-> out_data_r.busy_res)
    else $error("serial clock high while idle");

endmodule
